### rtl/core/rtpt_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and defaults for the touch press tracker
// no dependencies

package rtpt_pkg;

    localparam int DEF_POINT_DEPTH = 64;
    localparam int DEF_SEND_PERIOD = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_XY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEVEL  = 3'd4;

    localparam logic [8:0] RST_MOVE_THRESHOLD = 9'd10;
    localparam logic [7:0] RST_RELEASE_LEVEL  = 8'hf0;

    localparam logic [5:0] COUNT_SAT     = 6'd63;
    localparam int         GESTURE_MIN   = 3;

    typedef enum logic [1:0] {
        KIND_PRESSED  = 2'd0,
        KIND_GESTURE  = 2'd1,
        KIND_RELEASED = 2'd2
    } report_kind_t;

    typedef struct packed {
        logic [9:0] sample_first;
        logic [9:0] sample_second;
    } sample_req_t;

    typedef struct packed {
        report_kind_t report_kind;
        logic [7:0]   pos_x;
        logic [7:0]   pos_y;
        logic [5:0]   point_count;
        logic         last_of_run;
    } report_t;

    typedef struct packed {
        logic       invert_x;
        logic       invert_y;
        logic       swap_xy;
        logic [8:0] move_threshold;
        logic [7:0] release_level;
    } cfg_t;

    typedef struct packed {
        logic [1:0] n;
        report_t    r0;
        report_t    r1;
    } push_t;

endpackage

### rtl/core/rtpt_track.sv
`timescale 1ns / 1ps
// input register, tracking state and per-tick report logic
// depends on rtpt_pkg

module rtpt_track
    import rtpt_pkg::*;
#(
    parameter int POINT_DEPTH = DEF_POINT_DEPTH,
    parameter int SEND_PERIOD = DEF_SEND_PERIOD
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  sample_req_t s_data,
    input  cfg_t        cfg,
    input  logic        room,
    output push_t       push
);

    localparam int CW = $clog2(POINT_DEPTH);
    localparam int PW = (SEND_PERIOD > 1) ? $clog2(SEND_PERIOD) : 1;
    localparam logic [CW:0]   DEPTH_C = (CW + 1)'(POINT_DEPTH);
    localparam logic [PW:0]   PERIOD_C = (PW + 1)'(SEND_PERIOD);

    logic              in_vld_reg;
    sample_req_t       in_reg;
    logic              advance;

    logic [7:0]        sx_reg, sy_reg, sx_next, sy_next;
    logic [7:0]        tx_reg, ty_reg, tx_next, ty_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pressed_reg, pressed_next;
    logic [7:0]        tick_reg, tick_next;
    logic [PW-1:0]     phase_reg, phase_next;

    logic [7:0]        a, b, x, y, xi, yi, dx, dy;
    logic [8:0]        span;
    logic              touch, moved, store, send, gest;
    logic [CW:0]       cnt_inc;
    logic [PW:0]       phase_inc;
    logic [8:0]        cnt_wide;
    logic [5:0]        cnt_sat;
    report_t           rep_press, rep_gest, rep_rel;

    assign advance = in_vld_reg & room;
    assign s_ready = ~in_vld_reg | room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_comb begin
        a  = in_reg.sample_first[9:2];
        b  = in_reg.sample_second[9:2];
        x  = cfg.swap_xy ? b : a;
        y  = cfg.swap_xy ? a : b;
        touch = (x < cfg.release_level) && (y < cfg.release_level);
        xi = cfg.invert_x ? ~x : x;
        yi = cfg.invert_y ? ~y : y;
        dx = (sx_reg > xi) ? sx_reg - xi : xi - sx_reg;
        dy = (sy_reg > yi) ? sy_reg - yi : yi - sy_reg;
        span  = {1'b0, dx} + {1'b0, dy};
        moved = (cnt_reg != '0) && (span > cfg.move_threshold);
        store = (cnt_reg == '0) || moved;
        cnt_inc = {1'b0, cnt_reg} + 1'b1;

        tick_next = tick_reg + 8'd1;
        phase_inc = {1'b0, phase_reg} + 1'b1;
        if (tick_next == 8'd0 || phase_inc == PERIOD_C) begin
            phase_next = '0;
        end else begin
            phase_next = phase_inc[PW-1:0];
        end

        cnt_wide = 9'(cnt_reg);
        cnt_sat  = (cnt_wide > 9'(COUNT_SAT)) ? COUNT_SAT : cnt_wide[5:0];
        gest     = cnt_wide > 9'(GESTURE_MIN);

        sx_next = sx_reg;
        sy_next = sy_reg;
        tx_next = tx_reg;
        ty_next = ty_reg;
        cnt_next = cnt_reg;
        pressed_next = pressed_reg;
        send = 1'b0;

        if (touch) begin
            tx_next = xi;
            ty_next = yi;
            pressed_next = 1'b1;
            if (store) begin
                sx_next = xi;
                sy_next = yi;
                cnt_next = (cnt_inc == DEPTH_C) ? '0 : cnt_inc[CW-1:0];
            end
            send = (cnt_next == '0) || moved || (phase_next == '0);
        end else begin
            if (gest || pressed_reg) begin
                cnt_next = '0;
            end
            pressed_next = 1'b0;
        end

        rep_press = '{report_kind: KIND_PRESSED, pos_x: xi, pos_y: yi,
                      point_count: 6'd0, last_of_run: 1'b1};
        rep_gest  = '{report_kind: KIND_GESTURE, pos_x: 8'd0, pos_y: 8'd0,
                      point_count: cnt_sat, last_of_run: ~pressed_reg};
        rep_rel   = '{report_kind: KIND_RELEASED, pos_x: tx_reg, pos_y: ty_reg,
                      point_count: 6'd0, last_of_run: 1'b1};

        push.r1 = rep_rel;
        if (touch) begin
            push.r0 = rep_press;
            push.n  = {1'b0, send};
        end else begin
            push.r0 = gest ? rep_gest : rep_rel;
            push.n  = 2'({1'b0, gest} + {1'b0, pressed_reg});
        end
        if (!advance) begin
            push.n = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg      <= '0;
            sy_reg      <= '0;
            tx_reg      <= '0;
            ty_reg      <= '0;
            cnt_reg     <= '0;
            pressed_reg <= 1'b0;
            tick_reg    <= '0;
            phase_reg   <= '0;
        end else if (advance) begin
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            tx_reg      <= tx_next;
            ty_reg      <= ty_next;
            cnt_reg     <= cnt_next;
            pressed_reg <= pressed_next;
            tick_reg    <= tick_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

### rtl/core/rtpt_fifo.sv
`timescale 1ns / 1ps
// four-entry report queue taking up to two reports per cycle
// depends on rtpt_pkg

module rtpt_fifo
    import rtpt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output report_t m_data
);

    report_t     mem_reg [4];
    logic [1:0]  wr_reg, wr_next;
    logic [1:0]  rd_reg, rd_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        pop;

    assign m_valid = cnt_reg != 3'd0;
    assign m_data  = mem_reg[rd_reg];
    assign pop     = m_valid & m_ready;
    assign room    = cnt_reg <= 3'd2;

    always_comb begin
        wr_next  = wr_reg + push.n;
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, push.n} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push.n != 2'd0) begin
            mem_reg[wr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_reg + 2'd1] <= push.r1;
        end
    end

endmodule

### rtl/core/resistive_touch_press_tracker.sv
`timescale 1ns / 1ps
// top level of the touch press tracker: configuration registers and wiring
// depends on rtpt_pkg, rtpt_track, rtpt_fifo
//
// usage:
//   s_ channel: one request per poll tick, two 10-bit converter readings
//   m_ channel: zero, one or two reports per tick, in order
//   cfg channel: register index and data, always ready; write only while idle
//   a request is registered on acceptance, evaluated from the input register
//   once the queue has room, and its reports are written into the queue,
//   from which the first report is presented
//   throughput: one request per cycle while the receiver keeps up
//   the four-entry report queue decides s_ready: it drops when fewer than
//   two free slots remain and the input register is full
//   a stalled receiver fills the queue and then holds off new requests;
//   no report is lost
//   reset clears the tracking state, the queue and restores register
//   defaults (threshold 10, release level 240)

module resistive_touch_press_tracker
    import rtpt_pkg::*;
#(
    parameter int POINT_DEPTH = DEF_POINT_DEPTH,
    parameter int SEND_PERIOD = DEF_SEND_PERIOD
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sample_req_t           s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output report_t               m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    push_t push;
    logic  room;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{invert_x: 1'b0, invert_y: 1'b0, swap_xy: 1'b0,
                         move_threshold: RST_MOVE_THRESHOLD,
                         release_level: RST_RELEASE_LEVEL};
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_INVERT_X:       cfg_reg.invert_x       <= cfg_data[0];
                CFG_INVERT_Y:       cfg_reg.invert_y       <= cfg_data[0];
                CFG_SWAP_XY:        cfg_reg.swap_xy        <= cfg_data[0];
                CFG_MOVE_THRESHOLD: cfg_reg.move_threshold <= cfg_data;
                CFG_RELEASE_LEVEL:  cfg_reg.release_level  <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    rtpt_track #(
        .POINT_DEPTH (POINT_DEPTH),
        .SEND_PERIOD (SEND_PERIOD)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .room    (room),
        .push    (push)
    );

    rtpt_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
